// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define GFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GFD_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GFD_ASSERT(lbl, prop, msg)
`define GFD_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/gfd_pkg.sv =====
package gfd_pkg;

  localparam int DIGITS_PER_FIELD = 3;
  localparam int NUM_FIELDS       = 4;
  localparam int NUM_LAMPS        = 4;
  localparam int FIELD_CHARS      = NUM_FIELDS * DIGITS_PER_FIELD;
  localparam int FRAME_LEN        = FIELD_CHARS + NUM_LAMPS + 1;
  localparam int POS_W            = $clog2(FRAME_LEN);
  localparam int DIG_W            = (DIGITS_PER_FIELD > 1) ? $clog2(DIGITS_PER_FIELD) : 1;
  localparam int FLD_W            = $clog2(NUM_FIELDS);
  localparam int LAMP_W           = $clog2(NUM_LAMPS);

  localparam int FIELD_MAX        = 10 ** DIGITS_PER_FIELD - 1;
  localparam int FIELD_W          = $clog2(FIELD_MAX + 1);

  // Timer clock over prescaler and toggle factor gives the reload numerator.
  localparam int CPU_HZ           = 16000000;
  localparam int TIMER_DIV        = 2 * 64;
  localparam int PERIOD_NUM       = CPU_HZ / TIMER_DIV;
  localparam int DIV_W            = $clog2(PERIOD_NUM + 1);
  localparam int REM_W            = FIELD_W + 1;
  localparam int STEP_W           = $clog2(DIV_W);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [7:0] SEG_TABLE [0:7] = '{8'd68, 8'd100, 8'd160, 8'd213,
                                              8'd241, 8'd226, 8'd115, 8'd119};

  typedef struct packed {
    logic [7:0] ch;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  rpm;
    logic [9:0]  speed;
    logic [15:0] rpm_period;
    logic [15:0] speed_period;
    logic [7:0]  temp_duty;
    logic [7:0]  fuel_duty;
    logic        handbrake_lamp;
    logic        right_signal;
    logic        left_signal;
    logic        abs_lamp;
    logic [7:0]  gear_segments;
    logic        gear_valid;
  } out_item_t;

  // Decoded frame as seen by the datapath when the gear character arrives.
  typedef struct packed {
    logic [FIELD_W-1:0]   rpm_v;
    logic [FIELD_W-1:0]   spd_v;
    logic [FIELD_W-1:0]   temp_v;
    logic [FIELD_W-1:0]   fuel_v;
    logic [NUM_LAMPS-1:0] lamps;
    logic [7:0]           gear_seg;
    logic                 gear_valid;
  } frame_t;

  typedef struct packed {
    logic load_snap;
    logic div_start;
    logic div_sel_spd;
    logic div_step;
    logic save_rpm;
    logic save_spd;
    logic out_set;
  } ctrl_cmd_t;

  function automatic logic [15:0] period_of(input logic [FIELD_W-1:0] v,
                                            input logic [DIV_W-1:0]   q);
    logic [DIV_W-1:0] qm1;
    qm1 = q - DIV_W'(1);
    if (v < FIELD_W'(2)) begin
      return 16'hFFFF;
    end
    return qm1[15:0];
  endfunction

endpackage

// ===== rtl/gauge_frame_decoder.sv =====
// Channel   Ports                            Carries
// input     in_valid, in_stall, in_item      one frame character and start flag
// result    out_valid, out_stall, out_item   decoded gauge values, one per frame
//
// Characters are taken one per cycle unless in_stall is high. The gear character starts
// two divisions on one shared shift-subtract divider of 17 steps each, so input stalls
// while they run, and the result is registered when the speed division finishes.
// Reset is synchronous and clears position, field state and the result valid flag.
// A gear character stalls while the previous result has not been taken; other
// characters of the next frame flow in as usual.
`include "assert_macros.svh"

module gauge_frame_decoder import gfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  frame_t    frm;
  ctrl_cmd_t cmd;
  logic      busy;
  logic      at_gear;
  logic      gear_hit;
  logic      in_accept;

  assign in_stall  = busy || (out_valid && at_gear);
  assign in_accept = in_valid && !in_stall;

  gfd_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .item     (in_item),
    .frm      (frm),
    .at_gear  (at_gear),
    .gear_hit (gear_hit)
  );

  gfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .gear_hit (gear_hit),
    .cmd      (cmd),
    .busy     (busy)
  );

  gfd_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .frm       (frm),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // The result register must be free whenever a new frame completes.
  `GFD_NEVER(a_gear_slot_free, gear_hit && out_valid, "gear accepted while result pending")
  `GFD_ASSERT(a_result_after_div, $rose(out_valid) |-> $past(busy), "result without division")
  `GFD_ASSERT(a_div_after_gear, $rose(busy) |-> $past(gear_hit), "division without gear")

endmodule

// ===== rtl/gfd_parse.sv =====
module gfd_parse import gfd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output frame_t   frm,
  output logic     at_gear,
  output logic     gear_hit
);

  logic [POS_W-1:0]     pos_r;
  logic [DIG_W-1:0]     dig_r;
  logic [FLD_W-1:0]     fld_r;
  logic                 ended_r;
  logic                 seen_r;
  logic [FIELD_W-1:0]   fields_r [NUM_FIELDS];
  logic [NUM_LAMPS-1:0] lamps_r;

  logic [POS_W-1:0]     pos;
  logic [DIG_W-1:0]     dig;
  logic [FLD_W-1:0]     fld;
  logic                 dig0;
  logic                 in_fields;
  logic                 in_lamps;
  logic                 is_digit;
  logic                 is_blank;
  logic [3:0]           dval;
  logic                 ended_eff;
  logic                 seen_eff;
  logic [FIELD_W-1:0]   base;
  logic [FIELD_W+3:0]   acc_x10;
  logic [FIELD_W-1:0]   field_new;
  logic                 ended_nxt;
  logic                 seen_nxt;
  logic [POS_W-1:0]     lamp_off;
  logic [LAMP_W-1:0]    lamp_idx;
  logic [3:0]           gear;
  logic [POS_W-1:0]     pos_nxt;
  logic [DIG_W-1:0]     dig_nxt;
  logic [FLD_W-1:0]     fld_nxt;

  // A frame start forces position zero whatever the counters hold.
  assign pos  = item.frame_start ? '0 : pos_r;
  assign dig  = item.frame_start ? '0 : dig_r;
  assign fld  = item.frame_start ? '0 : fld_r;
  assign dig0 = (dig == '0);

  assign in_fields = (pos < POS_W'(FIELD_CHARS));
  assign in_lamps  = !in_fields && (pos < POS_W'(FRAME_LEN - 1));
  assign at_gear   = (pos_r == POS_W'(FRAME_LEN - 1));
  assign gear_hit  = accept && !item.frame_start && at_gear;

  always_comb begin
    is_digit = item.ch inside {[CH_ZERO:CH_NINE]};
    is_blank = item.ch inside {CH_SPACE, [CH_TAB:CH_CR]};
    dval     = 4'(item.ch - CH_ZERO);

    ended_eff = dig0 ? 1'b0 : ended_r;
    seen_eff  = dig0 ? 1'b0 : seen_r;
    base      = dig0 ? '0 : fields_r[fld];
    acc_x10   = ({4'b0, base} << 3) + ({4'b0, base} << 1) + (FIELD_W + 4)'(dval);
    field_new = (!ended_eff && is_digit) ? acc_x10[FIELD_W-1:0] : base;
    // Blanks are skipped only until the first digit; anything else ends the field.
    ended_nxt = ended_eff || (!is_digit && !(is_blank && !seen_eff));
    seen_nxt  = seen_eff || (!ended_eff && is_digit);

    lamp_off = pos - POS_W'(FIELD_CHARS);
    lamp_idx = lamp_off[LAMP_W-1:0];

    gear = is_digit ? dval : 4'd0;
  end

  always_comb begin
    if (pos == POS_W'(FRAME_LEN - 1)) begin
      pos_nxt = '0;
      dig_nxt = '0;
      fld_nxt = '0;
    end else begin
      pos_nxt = pos + POS_W'(1);
      dig_nxt = dig;
      fld_nxt = fld;
      if (in_fields) begin
        if (dig == DIG_W'(DIGITS_PER_FIELD - 1)) begin
          dig_nxt = '0;
          fld_nxt = fld + FLD_W'(1);
        end else begin
          dig_nxt = dig + DIG_W'(1);
        end
      end
    end
  end

  // Each field restarts from zero at its first character, so only the lamps need
  // clearing at the start of a frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      dig_r   <= '0;
      fld_r   <= '0;
      ended_r <= 1'b0;
      seen_r  <= 1'b0;
      lamps_r <= '0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        fields_r[i] <= '0;
      end
    end else if (accept) begin
      pos_r <= pos_nxt;
      dig_r <= dig_nxt;
      fld_r <= fld_nxt;
      if (pos == '0) begin
        lamps_r <= '0;
      end
      if (in_fields) begin
        fields_r[fld] <= field_new;
        ended_r       <= ended_nxt;
        seen_r        <= seen_nxt;
      end
      if (in_lamps) begin
        lamps_r[lamp_idx] <= is_digit && item.ch[0];
      end
    end
  end

  always_comb begin
    frm.rpm_v      = fields_r[0];
    frm.spd_v      = fields_r[1];
    frm.temp_v     = fields_r[2];
    frm.fuel_v     = fields_r[3];
    frm.lamps      = lamps_r;
    frm.gear_valid = !gear[3];
    frm.gear_seg   = gear[3] ? 8'd0 : SEG_TABLE[gear[2:0]];
  end

endmodule

// ===== rtl/gfd_dpath.sv =====
module gfd_dpath import gfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_cmd_t cmd,
  input  frame_t    frm,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_item
);

  out_item_t          out_r;
  logic               out_valid_r;
  logic [FIELD_W-1:0] rpm_v_r;
  logic [FIELD_W-1:0] spd_v_r;
  logic [FIELD_W-1:0] dvs_r;
  logic [REM_W-1:0]   rem_r;
  logic [DIV_W-1:0]   quo_r;

  logic [REM_W-1:0]   rem_sh;
  logic               ge;
  logic [REM_W-1:0]   rem_nxt;
  logic [DIV_W-1:0]   quo_nxt;

  // Restoring shift-subtract: one quotient bit per step, numerator shifts in from the top.
  always_comb begin
    rem_sh  = {rem_r[REM_W-2:0], quo_r[DIV_W-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= DIV_W'(PERIOD_NUM);
      dvs_r <= cmd.div_sel_spd ? spd_v_r : frm.rpm_v;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_snap) begin
      rpm_v_r              <= frm.rpm_v;
      spd_v_r              <= frm.spd_v;
      out_r.rpm            <= 10'(frm.rpm_v);
      out_r.speed          <= 10'(frm.spd_v);
      out_r.temp_duty      <= 8'(frm.temp_v);
      out_r.fuel_duty      <= 8'(frm.fuel_v);
      out_r.handbrake_lamp <= frm.lamps[0];
      out_r.right_signal   <= frm.lamps[1];
      out_r.left_signal    <= frm.lamps[2];
      out_r.abs_lamp       <= frm.lamps[3];
      out_r.gear_segments  <= frm.gear_seg;
      out_r.gear_valid     <= frm.gear_valid;
    end
    if (cmd.save_rpm) begin
      out_r.rpm_period <= period_of(rpm_v_r, quo_nxt);
    end
    if (cmd.save_spd) begin
      out_r.speed_period <= period_of(spd_v_r, quo_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_set) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/gfd_ctrl.sv =====
module gfd_ctrl import gfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      gear_hit,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  typedef enum logic [2:0] {
    ST_RECV    = 3'b001,
    ST_DIV_RPM = 3'b010,
    ST_DIV_SPD = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              last_step;

  assign last_step = (cnt_r == STEP_W'(DIV_W - 1));

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_RECV: begin
        if (gear_hit) begin
          cmd.load_snap = 1'b1;
          cmd.div_start = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_DIV_RPM;
        end
      end
      ST_DIV_RPM: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + STEP_W'(1);
        if (last_step) begin
          // Final rpm step also restarts the shared divider for speed.
          cmd.save_rpm    = 1'b1;
          cmd.div_start   = 1'b1;
          cmd.div_sel_spd = 1'b1;
          cnt_nxt         = '0;
          state_nxt       = ST_DIV_SPD;
        end
      end
      ST_DIV_SPD: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + STEP_W'(1);
        if (last_step) begin
          cmd.save_spd = 1'b1;
          cmd.out_set  = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_RECV;
        end
      end
      default: begin
        state_nxt = ST_RECV;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RECV;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = (state_r != ST_RECV);

endmodule

// ===== verif/gauge_frame_decoder_tb.sv =====
module gauge_frame_decoder_tb;
  import gfd_pkg::*;

  localparam int FIELD_DIGITS = 3;
  localparam int FIELD_COUNT = 4;
  localparam int LAMP_COUNT = 4;
  localparam int NUMERIC_CHARS = FIELD_COUNT * FIELD_DIGITS;
  localparam int FRAME_CHARS = NUMERIC_CHARS + LAMP_COUNT + 1;
  localparam int RELOAD_NUM = 125000;
  localparam int DIVIDE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_CHARS = 480;
  localparam int RANDOM_READOUTS = 24;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LETTER_A = 8'h41;
  localparam logic [7:0] CH_LETTER_X = 8'h78;
  localparam logic [7:0] BLANK_CHARS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  localparam logic [7:0] GEAR_GLYPH [8] = '{8'd68, 8'd100, 8'd160, 8'd213,
                                            8'd241, 8'd226, 8'd115, 8'd119};

  typedef logic [7:0] frame_chars_t [FRAME_CHARS];

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Decoder state tracked alongside the block.
  int          cur_pos;
  logic [15:0] field_val [FIELD_COUNT];
  logic        field_closed;
  logic        digit_seen;
  logic [3:0]  lamp_state;
  out_item_t   pending_readouts [$];

  int  mismatches;
  int  chars_accepted;
  int  readouts_due;
  int  readouts_checked;
  int  cycle_count;
  bit  calm;
  int  hold_cycles_req;

  gauge_frame_decoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] reload_for(input logic [15:0] v);
    if (v < 16'd2) begin
      return 16'hFFFF;
    end
    return 16'(RELOAD_NUM / int'(v) - 1);
  endfunction

  function automatic bit is_digit_char(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Advances the tracked decoder by one accepted character and queues a readout
  // when the character lands on the gear position.
  task automatic decode_frame_char(input logic [7:0] c, input logic fs);
    int        p;
    int        f;
    int        gear;
    bit        digit;
    bit        blank;
    out_item_t r;
    p = fs ? 0 : cur_pos;
    if (p >= FRAME_CHARS) p = 0;
    digit = is_digit_char(c);
    blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    if (p == 0) begin
      foreach (field_val[i]) field_val[i] = '0;
      lamp_state = '0;
    end
    if (p < NUMERIC_CHARS) begin
      f = p / FIELD_DIGITS;
      if (p % FIELD_DIGITS == 0) begin
        field_val[f] = '0;
        field_closed = 1'b0;
        digit_seen = 1'b0;
      end
      if (!field_closed) begin
        if (digit) begin
          field_val[f] = field_val[f] * 16'd10 + (16'(c) - 16'(CH_ZERO));
          digit_seen = 1'b1;
        end else if (!(blank && !digit_seen)) begin
          field_closed = 1'b1;
        end
      end
    end else if (p < NUMERIC_CHARS + LAMP_COUNT) begin
      lamp_state[p - NUMERIC_CHARS] = digit & c[0];
    end else begin
      gear = digit ? int'(c - CH_ZERO) : 0;
      r.rpm = field_val[0][9:0];
      r.speed = field_val[1][9:0];
      r.rpm_period = reload_for(field_val[0]);
      r.speed_period = reload_for(field_val[1]);
      r.temp_duty = field_val[2][7:0];
      r.fuel_duty = field_val[3][7:0];
      r.handbrake_lamp = lamp_state[0];
      r.right_signal = lamp_state[1];
      r.left_signal = lamp_state[2];
      r.abs_lamp = lamp_state[3];
      r.gear_valid = gear < 8;
      r.gear_segments = (gear < 8) ? GEAR_GLYPH[gear] : 8'd0;
      pending_readouts.push_back(r);
      readouts_due++;
    end
    p++;
    cur_pos = (p >= FRAME_CHARS) ? 0 : p;
  endtask

  // Offers one character and returns at the edge where the transaction completes.
  // Valid is left high so that a following character goes out without a bubble.
  task automatic send_char(input logic [7:0] c, input logic fs);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_item <= '{ch: c, frame_start: fs};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    decode_frame_char(c, fs);
    chars_accepted++;
  endtask

  task automatic send_frame(input frame_chars_t chars, input logic fs, input int len);
    for (int i = 0; i < len; i++) begin
      send_char(chars[i], (i == 0) ? fs : 1'b0);
    end
  endtask

  function automatic logic [7:0] field_char();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return CH_ZERO + 8'($urandom_range(0, 9));
    if (pick < 16) return BLANK_CHARS[$urandom_range(0, 5)];
    if (pick == 16) return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic frame_chars_t make_frame();
    frame_chars_t fr;
    for (int f = 0; f < FIELD_COUNT; f++) begin
      // Now and then a field that reads as 0, 1 or 2, so saturation is hit often.
      if ($urandom_range(0, 7) == 0) begin
        fr[f * FIELD_DIGITS] = CH_SPACE;
        fr[f * FIELD_DIGITS + 1] = BLANK_CHARS[$urandom_range(0, 5)];
        fr[f * FIELD_DIGITS + 2] = CH_ZERO + 8'($urandom_range(0, 2));
      end else begin
        for (int d = 0; d < FIELD_DIGITS; d++) fr[f * FIELD_DIGITS + d] = field_char();
      end
    end
    for (int l = 0; l < LAMP_COUNT; l++) begin
      fr[NUMERIC_CHARS + l] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                           : CH_ZERO + 8'($urandom_range(0, 9));
    end
    fr[FRAME_CHARS - 1] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                       : CH_ZERO + 8'($urandom_range(0, 9));
    return fr;
  endfunction

  // Result side: random stall bursts, plus a long hold when a test asks for one.
  initial begin : result_receiver
    int hold;
    forever begin
      @(posedge clk);
      if (hold_cycles_req > 0) begin
        hold = hold_cycles_req;
        hold_cycles_req = 0;
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readouts.size() == 0) begin
        $display("%0t: unexpected readout, expected none, got %h", $time, out_item);
        mismatches++;
      end else begin
        want = pending_readouts.pop_front();
        compare_field("rpm", want.rpm, out_item.rpm);
        compare_field("speed", want.speed, out_item.speed);
        compare_field("rpm_period", want.rpm_period, out_item.rpm_period);
        compare_field("speed_period", want.speed_period, out_item.speed_period);
        compare_field("temp_duty", want.temp_duty, out_item.temp_duty);
        compare_field("fuel_duty", want.fuel_duty, out_item.fuel_duty);
        compare_field("handbrake_lamp", want.handbrake_lamp, out_item.handbrake_lamp);
        compare_field("right_signal", want.right_signal, out_item.right_signal);
        compare_field("left_signal", want.left_signal, out_item.left_signal);
        compare_field("abs_lamp", want.abs_lamp, out_item.abs_lamp);
        compare_field("gear_segments", want.gear_segments, out_item.gear_segments);
        compare_field("gear_valid", want.gear_valid, out_item.gear_valid);
        readouts_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Blanks before and after digits, signs, non-digit lamps, an out-of-table gear,
  // a non-digit gear, field extremes and a frame abandoned by a new start flag.
  task automatic test_directed_frames();
    frame_chars_t fr;
    fr = '{"9", "9", "9", CH_FF, CH_SPACE, "2", CH_LF, "7", CH_SPACE,
           CH_MINUS, "5", "5", "1", "0", CH_LETTER_X, "9", "8"};
    send_frame(fr, 1'b1, FRAME_CHARS);
    send_char("1", 1'b1);
    send_char("2", 1'b0);
    fr = '{CH_TAB, CH_CR, "1", CH_VT, CH_PLUS, "5", "2", "5", "5",
           "9", "9", "9", "3", "2", "7", "0", CH_LETTER_A};
    send_frame(fr, 1'b1, FRAME_CHARS);
  endtask

  // Mostly whole frames with random content; the rest is truncated frames and noise.
  task automatic test_random_frames();
    int  start_chars;
    int  start_due;
    int  kind;
    int  n;
    bit  aligned;
    start_chars = chars_accepted;
    start_due = readouts_due;
    aligned = 1'b1;
    while (chars_accepted - start_chars < RANDOM_CHARS ||
           readouts_due - start_due < RANDOM_READOUTS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        n = $urandom_range(1, 10);
        repeat (n) send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        aligned = 1'b0;
      end else if (kind == 1) begin
        send_frame(make_frame(), 1'b1, $urandom_range(1, FRAME_CHARS - 1));
        aligned = 1'b0;
      end else begin
        send_frame(make_frame(), aligned ? 1'($urandom_range(0, 1)) : 1'b1, FRAME_CHARS);
        aligned = 1'b1;
      end
    end
  endtask

  // The receiver holds off while frames keep coming, so the held readout blocks the
  // next gear character and the input channel stalls.
  task automatic test_result_backpressure();
    hold_cycles_req = 300;
    repeat (5) send_frame(make_frame(), 1'b1, FRAME_CHARS);
  endtask

  task automatic test_full_rate();
    calm = 1'b1;
    repeat (6) send_frame(make_frame(), 1'b0, FRAME_CHARS);
  endtask

  initial begin
    cur_pos = 0;
    foreach (field_val[i]) field_val[i] = '0;
    field_closed = 1'b0;
    digit_seen = 1'b0;
    lamp_state = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_random_frames();
    test_result_backpressure();
    test_full_rate();

    in_valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (DIVIDE_CYCLES) @(posedge clk);

    $display("Sent %0d characters covering whole, abandoned and noisy frames;", chars_accepted);
    $display("checked %0d decoded readouts, with long result hold-off and full-rate input.",
             readouts_checked);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
